FILE: rtl/mf3_pkg.sv
package mf3_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Fixed frame geometry
    localparam int MAX_HEIGHT     = 4096;
    localparam int ROW_BITS       = 12;
    localparam int HGT_BITS       = 13;
    localparam int CFG_WIDTH_BITS = 11;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;

    // Configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 16;

    // Row store: four row banks, selected by row mod 4
    localparam int STORE_ROWS = 4;
    localparam int BANK_BITS  = 2;

    // 3x3 window and ranking
    localparam int WIN_DIM   = 3;
    localparam int WIN_SIZE  = 9;
    localparam int RANK_BITS = 4;

    // Result queue
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = 3;
    localparam int FIFO_CNT_BITS = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } cfg_reg_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_FLUSH = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] pixel_value;
    } mf3_in_t;

    typedef struct packed {
        logic [7:0] median_value;
        logic       frame_end;
    } mf3_out_t;

    // One output job: which neighbors exist and which bank holds the center row
    typedef struct packed {
        logic                 valid;
        logic                 frame_end;
        logic                 has_up;
        logic                 has_down;
        logic                 has_left;
        logic                 has_right;
        logic [BANK_BITS-1:0] bank;
    } mf3_job_t;

endpackage

FILE: rtl/mf3_ram.sv
module mf3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr_a,
    input  logic [ADDR_BITS-1:0] raddr_b,
    output logic [WIDTH-1:0]     rdata_a,
    output logic [WIDTH-1:0]     rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // Read returns the old word on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

FILE: rtl/mf3_ctrl.sv
module mf3_ctrl #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF,
    localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mf3_pkg::mf3_in_t                    s_data,
    input  logic                                room,
    output logic                                wr_en,
    output logic [mf3_pkg::BANK_BITS-1:0]       wr_bank,
    output logic [COL_BITS-1:0]                 wr_addr,
    output logic [PIXEL_BITS-1:0]               wr_data,
    output mf3_pkg::mf3_job_t                   job,
    output logic [COL_BITS-1:0]                 job_col
);

    localparam int W_BITS      = $clog2(MAX_WIDTH + 1);
    localparam int RESET_W_EFF = (mf3_pkg::RESET_WIDTH > MAX_WIDTH) ?
                                 MAX_WIDTH : mf3_pkg::RESET_WIDTH;

    logic [W_BITS-1:0]                 width_reg, width_next;
    logic [mf3_pkg::HGT_BITS-1:0]      height_reg, height_next;
    logic [COL_BITS-1:0]               in_col_reg, in_col_next;
    logic [mf3_pkg::ROW_BITS-1:0]      in_row_reg, in_row_next;
    logic [COL_BITS-1:0]               out_col_reg, out_col_next;
    logic [mf3_pkg::ROW_BITS-1:0]      out_row_reg, out_row_next;
    logic                              done_reg, done_next;
    mf3_pkg::mf3_job_t                 job_reg, job_next;
    logic [COL_BITS-1:0]               job_col_reg;

    logic                              accept;
    logic                              take_pixel;
    logic                              in_col_last, in_row_last;
    logic                              out_col_last, out_row_last;
    logic [COL_BITS-1:0]               need_col;
    logic [mf3_pkg::ROW_BITS-1:0]      need_row;
    logic                              out_ready;
    logic                              emit;
    logic [mf3_pkg::CFG_WIDTH_BITS-1:0] cfg_w;
    logic [mf3_pkg::HGT_BITS-1:0]      cfg_h;

    assign cfg_ready = 1'b1;
    assign s_ready   = room;
    assign accept    = s_valid && s_ready;
    assign take_pixel = accept && (s_data.mode == mf3_pkg::MODE_PIXEL) && !done_reg;

    assign in_col_last  = (W_BITS'(in_col_reg) + W_BITS'(1)) == width_reg;
    assign in_row_last  = (mf3_pkg::HGT_BITS'(in_row_reg) + mf3_pkg::HGT_BITS'(1)) == height_reg;
    assign out_col_last = (W_BITS'(out_col_reg) + W_BITS'(1)) == width_reg;
    assign out_row_last = (mf3_pkg::HGT_BITS'(out_row_reg) + mf3_pkg::HGT_BITS'(1)) == height_reg;

    assign need_col = out_col_last ? out_col_reg : out_col_reg + 1'b1;
    assign need_row = out_row_last ? out_row_reg : out_row_reg + 1'b1;

    assign cfg_w = cfg_data[mf3_pkg::CFG_WIDTH_BITS-1:0];
    assign cfg_h = cfg_data[mf3_pkg::HGT_BITS-1:0];

    assign wr_en   = take_pixel;
    assign wr_bank = in_row_reg[mf3_pkg::BANK_BITS-1:0];
    assign wr_addr = in_col_reg;
    assign wr_data = PIXEL_BITS'(s_data.pixel_value);

    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        done_next    = done_reg;

        // Advance the input position
        if (take_pixel) begin
            if (in_col_last) begin
                in_col_next = '0;
                if (in_row_last) begin
                    in_row_next = '0;
                    done_next   = 1'b1;
                end else begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end

        // The next output is ready once its lower-right neighbor has arrived
        out_ready = done_next || (in_row_next > need_row) ||
                    ((in_row_next == need_row) && (in_col_next > need_col));
        emit = accept && out_ready;

        job_next.valid     = emit;
        job_next.frame_end = out_row_last && out_col_last;
        job_next.has_up    = out_row_reg != '0;
        job_next.has_down  = !out_row_last;
        job_next.has_left  = out_col_reg != '0;
        job_next.has_right = !out_col_last;
        job_next.bank      = out_row_reg[mf3_pkg::BANK_BITS-1:0];

        if (emit) begin
            if (out_row_last && out_col_last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                done_next    = 1'b0;
            end else if (out_col_last) begin
                out_col_next = '0;
                out_row_next = out_row_reg + 1'b1;
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
        end

        // A width or height write restarts the frame; clamp the value into range
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mf3_pkg::REG_IMAGE_WIDTH: begin
                    if (cfg_w == '0) begin
                        width_next = W_BITS'(1);
                    end else if (32'(cfg_w) > MAX_WIDTH) begin
                        width_next = W_BITS'(MAX_WIDTH);
                    end else begin
                        width_next = W_BITS'(cfg_w);
                    end
                end
                mf3_pkg::REG_IMAGE_HEIGHT: begin
                    if (cfg_h == '0) begin
                        height_next = mf3_pkg::HGT_BITS'(1);
                    end else if (32'(cfg_h) > mf3_pkg::MAX_HEIGHT) begin
                        height_next = mf3_pkg::HGT_BITS'(mf3_pkg::MAX_HEIGHT);
                    end else begin
                        height_next = cfg_h;
                    end
                end
                default: begin
                end
            endcase
            if ((cfg_index == mf3_pkg::REG_IMAGE_WIDTH) ||
                (cfg_index == mf3_pkg::REG_IMAGE_HEIGHT)) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                done_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= W_BITS'(RESET_W_EFF);
            height_reg  <= mf3_pkg::HGT_BITS'(mf3_pkg::RESET_HEIGHT);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            done_reg    <= 1'b0;
            job_reg     <= '0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            done_reg    <= done_next;
            job_reg     <= job_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_col_reg <= out_col_reg;
    end

    assign job     = job_reg;
    assign job_col = job_col_reg;

endmodule

FILE: rtl/mf3_median.sv
module mf3_median #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  mf3_pkg::mf3_job_t                                    job,
    input  logic [mf3_pkg::STORE_ROWS-1:0][PIXEL_BITS-1:0]       rd_a,
    input  logic [mf3_pkg::STORE_ROWS-1:0][PIXEL_BITS-1:0]       rd_b,
    output logic                                                 res_valid,
    output mf3_pkg::mf3_out_t                                    res,
    output logic [1:0]                                           inflight
);

    mf3_pkg::mf3_job_t                 job2_reg;
    logic [PIXEL_BITS-1:0]             left_col_reg [mf3_pkg::WIN_DIM];

    logic                              s3_valid_reg;
    logic                              s3_end_reg;
    logic [PIXEL_BITS-1:0]             s3_win_reg [mf3_pkg::WIN_SIZE];
    logic [mf3_pkg::WIN_SIZE-1:0]      s3_vmask_reg;
    logic [mf3_pkg::WIN_SIZE-1:0]      s3_lt_reg [mf3_pkg::WIN_SIZE];
    logic [mf3_pkg::RANK_BITS-1:0]     s3_half_reg;

    logic [mf3_pkg::BANK_BITS-1:0]     row_bank [mf3_pkg::WIN_DIM];
    logic                              row_ok [mf3_pkg::WIN_DIM];
    logic                              col_ok [mf3_pkg::WIN_DIM];
    logic [PIXEL_BITS-1:0]             center [mf3_pkg::WIN_DIM];
    logic [PIXEL_BITS-1:0]             win [mf3_pkg::WIN_SIZE];
    logic [mf3_pkg::WIN_SIZE-1:0]      vmask;
    logic [mf3_pkg::WIN_SIZE-1:0]      lt [mf3_pkg::WIN_SIZE];
    logic [mf3_pkg::RANK_BITS-1:0]     half;
    logic [PIXEL_BITS-1:0]             median;

    // Assemble the window: left column from the previous job, the rest from the banks
    always_comb begin
        row_bank[0] = job2_reg.bank - mf3_pkg::BANK_BITS'(1);
        row_bank[1] = job2_reg.bank;
        row_bank[2] = job2_reg.bank + mf3_pkg::BANK_BITS'(1);
        row_ok[0]   = job2_reg.has_up;
        row_ok[1]   = 1'b1;
        row_ok[2]   = job2_reg.has_down;
        col_ok[0]   = job2_reg.has_left;
        col_ok[1]   = 1'b1;
        col_ok[2]   = job2_reg.has_right;
        for (int r = 0; r < mf3_pkg::WIN_DIM; r++) begin
            center[r] = rd_a[row_bank[r]];
            win[mf3_pkg::WIN_DIM * r]     = left_col_reg[r];
            win[mf3_pkg::WIN_DIM * r + 1] = center[r];
            win[mf3_pkg::WIN_DIM * r + 2] = rd_b[row_bank[r]];
            for (int c = 0; c < mf3_pkg::WIN_DIM; c++) begin
                vmask[mf3_pkg::WIN_DIM * r + c] = row_ok[r] && col_ok[c];
            end
        end
        // lt[i][j]: neighbor j sorts ahead of neighbor i (ties broken by position)
        for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
            for (int j = 0; j < mf3_pkg::WIN_SIZE; j++) begin
                lt[i][j] = vmask[j] && ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
            end
        end
        half = mf3_pkg::RANK_BITS'($countones(vmask)) >> 1;
    end

    // Pick the neighbor whose rank is the upper median
    always_comb begin
        median = '0;
        for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
            if (s3_vmask_reg[i] &&
                (mf3_pkg::RANK_BITS'($countones(s3_lt_reg[i])) == s3_half_reg)) begin
                median = median | s3_win_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job2_reg     <= '0;
            s3_valid_reg <= 1'b0;
        end else begin
            job2_reg     <= job;
            s3_valid_reg <= job2_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        s3_end_reg   <= job2_reg.frame_end;
        s3_vmask_reg <= vmask;
        s3_half_reg  <= half;
        for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
            s3_win_reg[i] <= win[i];
            s3_lt_reg[i]  <= lt[i];
        end
        // Hold the center column as the next job's left column
        if (job2_reg.valid) begin
            for (int r = 0; r < mf3_pkg::WIN_DIM; r++) begin
                left_col_reg[r] <= center[r];
            end
        end
    end

    assign res_valid        = s3_valid_reg;
    assign res.median_value = 8'(median);
    assign res.frame_end    = s3_end_reg;
    assign inflight         = {1'b0, job2_reg.valid} + {1'b0, s3_valid_reg};

endmodule

FILE: rtl/mf3_fifo.sv
module mf3_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  mf3_pkg::mf3_out_t                  push_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mf3_pkg::mf3_out_t                  m_data,
    output logic [mf3_pkg::FIFO_CNT_BITS-1:0]  count
);

    mf3_pkg::mf3_out_t                    entry_reg [mf3_pkg::FIFO_DEPTH];
    logic [mf3_pkg::FIFO_PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mf3_pkg::FIFO_PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mf3_pkg::FIFO_CNT_BITS-1:0]    count_reg, count_next;
    logic                                 pop;

    assign m_valid = count_reg != '0;
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign count   = count_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/median_filter_3x3_border_excluded.sv
// Channel  | Ports                                        | Beat carries
// ---------+----------------------------------------------+---------------------------------
// input    | s_valid, s_ready, s_data                     | mode, pixel_value
// result   | m_valid, m_ready, m_data                     | median_value, frame_end
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | register index, write data
//
// One input beat per clock while s_ready is high. A result enters the output queue
// after the job register, the row-store read and the pairwise compare stage;
// the rank select is combinational on the compare stage's registers.
// The first result of a frame needs the pixels through row 1, column 1.
// Reset is synchronous, active low; the row store is not cleared.
// s_ready drops only when the eight-entry output queue plus jobs in flight
// would overflow; a stalled m_ready therefore stalls input after a few beats.
module median_filter_3x3_border_excluded #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mf3_pkg::mf3_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mf3_pkg::mf3_out_t                   m_data
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    logic                                          room;
    logic                                          wr_en;
    logic [mf3_pkg::BANK_BITS-1:0]                 wr_bank;
    logic [COL_BITS-1:0]                           wr_addr;
    logic [PIXEL_BITS-1:0]                         wr_data;
    mf3_pkg::mf3_job_t                             job;
    logic [COL_BITS-1:0]                           job_col;
    logic [COL_BITS-1:0]                           job_col_right;
    logic [mf3_pkg::STORE_ROWS-1:0][PIXEL_BITS-1:0] rd_a;
    logic [mf3_pkg::STORE_ROWS-1:0][PIXEL_BITS-1:0] rd_b;
    logic                                          res_valid;
    mf3_pkg::mf3_out_t                             res;
    logic [1:0]                                    inflight;
    logic [mf3_pkg::FIFO_CNT_BITS-1:0]             fifo_count;
    logic [mf3_pkg::FIFO_CNT_BITS-1:0]             pending;

    // Reserve a queue slot for every job already in the pipeline
    assign pending = fifo_count + mf3_pkg::FIFO_CNT_BITS'(job.valid) +
                     mf3_pkg::FIFO_CNT_BITS'(inflight);
    assign room    = pending < mf3_pkg::FIFO_CNT_BITS'(mf3_pkg::FIFO_DEPTH);

    // Counters, readiness test and pixel writes
    mf3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .room      (room),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job       (job),
        .job_col   (job_col)
    );

    // Read the center and right columns at the registered job column,
    // so the pixel written with the deciding beat is already in place
    assign job_col_right = job_col + 1'b1;

    // Row store: one bank per row mod 4, indexed by column
    for (genvar b = 0; b < mf3_pkg::STORE_ROWS; b++) begin : g_bank
        mf3_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .aclk    (aclk),
            .we      (wr_en && (wr_bank == mf3_pkg::BANK_BITS'(b))),
            .waddr   (wr_addr),
            .wdata   (wr_data),
            .raddr_a (job_col),
            .raddr_b (job_col_right),
            .rdata_a (rd_a[b]),
            .rdata_b (rd_b[b])
        );
    end

    // Window assembly, pairwise compare, rank select
    mf3_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job       (job),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .res_valid (res_valid),
        .res       (res),
        .inflight  (inflight)
    );

    // Output queue parts the result side from the pipeline
    mf3_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .count     (fifo_count)
    );

endmodule

FILE: tb/mf3_median_checker.sv
`timescale 1ns / 100ps

module mf3_median_checker
    import mf3_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  mf3_in_t                   s_data,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  mf3_out_t                  m_data,
    output int                        fail_count,
    output int                        medians_pending,
    output int                        frames_predicted,
    output int                        medians_checked
);

    localparam int ROW_LEN      = MAX_WIDTH_DEF;
    localparam int REPORT_LIMIT = 10;

    logic [CFG_WIDTH_BITS-1:0] width_reg;
    logic [HGT_BITS-1:0]       height_reg;
    logic [7:0]                line_bank [STORE_ROWS][ROW_LEN];
    int unsigned               in_col, in_row, out_col, out_row;
    bit                        frame_loaded;
    mf3_out_t                  median_q [$];
    int                        failures = 0;
    int                        frames_seen = 0;
    int                        checked = 0;

    function automatic int unsigned active_width();
        if (width_reg == '0) return 1;
        if (width_reg > ROW_LEN) return ROW_LEN;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == '0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void restart_frame();
        in_col       = 0;
        in_row       = 0;
        out_col      = 0;
        out_row      = 0;
        frame_loaded = 1'b0;
    endfunction

    function automatic void clear_state();
        int b, c;
        width_reg  = CFG_WIDTH_BITS'(RESET_WIDTH);
        height_reg = HGT_BITS'(RESET_HEIGHT);
        for (b = 0; b < STORE_ROWS; b++)
            for (c = 0; c < ROW_LEN; c++)
                line_bank[b][c] = '0;
        median_q.delete();
        restart_frame();
    endfunction

    // Median of the in-image part of the 3x3 window around the next output pixel;
    // an even count takes the upper of the two middle values.
    function automatic logic [7:0] window_median(int unsigned w, int unsigned h);
        logic [7:0] vals [9];
        logic [7:0] v;
        int         n, i, j, r, c, dr, dc;
        n = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                r = int'(out_row) + dr;
                c = int'(out_col) + dc;
                if (r >= 0 && c >= 0 && r < int'(h) && c < int'(w)) begin
                    vals[n] = line_bank[r % STORE_ROWS][c];
                    n++;
                end
            end
        end
        for (i = 1; i < n; i++) begin
            v = vals[i];
            j = i;
            while (j > 0 && vals[j - 1] > v) begin
                vals[j] = vals[j - 1];
                j--;
            end
            vals[j] = v;
        end
        return vals[n / 2];
    endfunction

    function automatic void absorb_beat(mf3_in_t beat);
        int unsigned w, h, need_r, need_c;
        mf3_out_t    res;
        w = active_width();
        h = active_height();
        // Store the pixel unless the frame is fully loaded; then the beat acts as a flush.
        if (beat.mode == MODE_PIXEL && !frame_loaded) begin
            line_bank[in_row % STORE_ROWS][in_col] = beat.pixel_value;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) begin
                    in_row       = 0;
                    frame_loaded = 1'b1;
                end
            end
        end
        need_r = (out_row + 1 < h) ? out_row + 1 : h - 1;
        need_c = (out_col + 1 < w) ? out_col + 1 : w - 1;
        if (!frame_loaded && in_row * w + in_col <= need_r * w + need_c)
            return;
        res.median_value = window_median(w, h);
        res.frame_end    = (out_row == h - 1 && out_col == w - 1);
        if (res.frame_end) begin
            frames_seen++;
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        median_q = {median_q, res};
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] median check: %s", $time, msg);
    endfunction

    function automatic void check_median(mf3_out_t got);
        mf3_out_t want;
        if (median_q.size() == 0) begin
            note_failure($sformatf("unexpected beat median=%0d frame_end=%0b",
                                   got.median_value, got.frame_end));
            return;
        end
        want = median_q.pop_front();
        checked++;
        if (got.median_value !== want.median_value || got.frame_end !== want.frame_end)
            note_failure($sformatf("beat %0d: median exp %0d got %0d, frame_end exp %0b got %0b",
                                   checked, want.median_value, got.median_value,
                                   want.frame_end, got.frame_end));
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: begin
                        width_reg = cfg_data[CFG_WIDTH_BITS-1:0];
                        restart_frame();
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg = cfg_data[HGT_BITS-1:0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                absorb_beat(s_data);
            if (m_valid && m_ready)
                check_median(m_data);
        end
        fail_count       <= failures;
        medians_pending  <= median_q.size();
        frames_predicted <= frames_seen;
        medians_checked  <= checked;
    end

endmodule

FILE: tb/median_filter_3x3_border_excluded_tb.sv
`timescale 1ns / 100ps

module median_filter_3x3_border_excluded_tb;
    import mf3_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 6;
    // idle time before a register write: pipeline depth plus margin
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 20;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PIXELS = 200;

    // an index outside the register map: a write there must leave the frame alone
    localparam logic [CFG_INDEX_BITS-1:0] UNUSED_REG_INDEX = 4'hF;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_CHOKED,
        RX_SPARSE
    } rx_style_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    mf3_in_t                   s_data = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    mf3_out_t                  m_data;

    int          fail_count;
    int          medians_pending;
    int          frames_predicted;
    int          medians_checked;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    int          pixel_beats = 0;
    int          flush_beats = 0;
    int          reg_writes = 0;
    rx_style_t   rx_style = RX_OPEN;
    logic [7:0]  rx_tick = '0;

    // salt-and-pepper checkerboard plus alternating bit patterns in the last row
    logic [7:0] pattern_3x3 [9] = '{8'hFF, 8'h00, 8'hFF,
                                    8'h00, 8'hFF, 8'h00,
                                    8'hAA, 8'h55, 8'h80};

    median_filter_3x3_border_excluded u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    mf3_median_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data),
        .fail_count       (fail_count),
        .medians_pending  (medians_pending),
        .frames_predicted (frames_predicted),
        .medians_checked  (medians_checked)
    );

    always begin
        #(CLK_HALF_NS) aclk = 1'b1;
        #(CLK_HALF_NS) aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver: pick a new stall style each time the tick counter wraps. Open passes
    // every beat, random drops one in four, choked raises ready while the low tick
    // bits are below four, sparse raises ready with a chance of one in five.
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick == 8'd0)
            rx_style <= rx_style_t'($urandom_range(0, 3));
        case (rx_style)
            RX_OPEN:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
            RX_CHOKED: m_ready <= (rx_tick[3:0] < 4'd4);
            default:   m_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // Abort a hung run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic mf3_in_t pixel_beat(logic [7:0] value);
        mf3_in_t beat;
        beat.mode        = MODE_PIXEL;
        beat.pixel_value = value;
        return beat;
    endfunction

    // The pixel field of a flush is don't-care; fill it with junk.
    function automatic mf3_in_t flush_beat();
        mf3_in_t beat;
        beat.mode        = MODE_FLUSH;
        beat.pixel_value = 8'($urandom);
        return beat;
    endfunction

    // Mostly mid-grey with salt and pepper, some full-range values.
    function automatic logic [7:0] noisy_pixel();
        logic [7:0] value;
        case ($urandom_range(0, 7))
            0:       value = 8'h00;
            1:       value = 8'hFF;
            2, 3:    value = 8'($urandom);
            default: value = 8'($urandom_range(90, 170));
        endcase
        return value;
    endfunction

    // All stimulus tasks enter and leave on a falling edge, so every input
    // changes at a falling edge and sees at most one assignment per step.

    // Present one beat and hold it until accepted. Open a random gap first
    // whenever the current burst is used up; some bursts run long with no gap.
    task automatic send_beat(input mf3_in_t beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid            <= 1'b0;
                s_data.pixel_value <= 8'($urandom);
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (beat.mode == MODE_PIXEL)
            pixel_beats++;
        else
            flush_beats++;
    endtask

    // Drop input valid, wait for every predicted median to come out, then give
    // the pipeline time to empty so that a register write lands on an idle block.
    task automatic settle();
        s_valid <= 1'b0;
        while (medians_pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_BITS'(value);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    task automatic configure(input int unsigned w_val, input int unsigned h_val);
        settle();
        write_reg(REG_IMAGE_WIDTH, w_val);
        write_reg(REG_IMAGE_HEIGHT, h_val);
    endtask

    // Push pixels with an occasional flush in between; flushes here mostly
    // arrive before the next output is ready and must produce nothing.
    task automatic feed_pixels(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(flush_beat());
            end else begin
                send_beat(pixel_beat(noisy_pixel()));
                sent++;
            end
        end
    endtask

    // Drain the tail of a loaded frame. Mix in pixels: after the last pixel of a
    // frame they are dropped and behave as flushes. Stop at the frame end beat.
    task automatic drain_frame(input int goal);
        while (frames_predicted < goal)
            send_beat(($urandom_range(0, 3) == 0) ? pixel_beat(noisy_pixel()) : flush_beat());
    endtask

    task automatic run_frame(input int unsigned w_val, input int unsigned h_val,
                             input int count, input bit complete);
        int goal;
        configure(w_val, h_val);
        goal = frames_predicted + 1;
        feed_pixels(count);
        if (complete)
            drain_frame(goal);
    endtask

    initial begin : stimulus
        int          goal;
        int          random_start;
        int          drain_wait;
        int unsigned cur_w, cur_h;
        bit          need_config;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part ----
        // A few beats on the reset geometry (640x480): far too few for any output.
        send_beat(pixel_beat(8'h00));
        send_beat(pixel_beat(8'hFF));
        send_beat(flush_beat());

        // 3x3 frame: corners see four neighbors, edges six, the center nine.
        // Lead with a flush that comes too early, follow the last pixel with an
        // extra pixel that must be dropped, then drain.
        configure(3, 3);
        goal = frames_predicted + 1;
        send_beat(flush_beat());
        foreach (pattern_3x3[i])
            send_beat(pixel_beat(pattern_3x3[i]));
        send_beat(pixel_beat(8'h7F));
        drain_frame(goal);

        // 2x2 frame with two whites and two blacks: every window is even, so
        // every output takes the upper median (white).
        configure(2, 2);
        goal = frames_predicted + 1;
        send_beat(pixel_beat(8'hFF));
        send_beat(pixel_beat(8'h00));
        send_beat(pixel_beat(8'h00));
        send_beat(pixel_beat(8'hFF));
        drain_frame(goal);

        // ---- register extremes ----
        random_start = pixel_beats;
        run_frame(1, 1, 1, 1'b1);          // single pixel frame
        run_frame(0, 5, 5, 1'b1);          // width zero acts as one
        run_frame(2048, 3, 3, 1'b1);       // bits above the width field are dropped
        run_frame(5, 0, 5, 1'b1);          // height zero acts as one
        run_frame(2047, 1, 60, 1'b0);      // width clamps to the row store; cut short
        run_frame(1024, 1, 30, 1'b0);
        run_frame(1, 8191, 60, 1'b0);      // height clamps to 4096; cut short
        run_frame(3, 4096, 40, 1'b0);

        // Write an unmapped index in the middle of a frame, then finish the frame.
        run_frame(5, 6, 20, 1'b0);
        settle();
        write_reg(UNUSED_REG_INDEX, $urandom);
        goal = frames_predicted + 1;
        feed_pixels(10);
        drain_frame(goal);

        // ---- random frames ----
        // Small random geometries with junk in the unused upper data bits.
        // Some frames run back to back on the same setting, some are abandoned
        // part way and cut off by the next register write.
        need_config = 1'b1;
        cur_w = 1;
        cur_h = 1;
        random_start = pixel_beats;
        while (pixel_beats - random_start < RANDOM_PIXELS) begin
            if (need_config || $urandom_range(0, 2) != 0) begin
                cur_w = $urandom_range(1, 12);
                cur_h = $urandom_range(1, 10);
                configure(cur_w | ($urandom_range(0, 31) << CFG_WIDTH_BITS),
                          cur_h | ($urandom_range(0, 7) << HGT_BITS));
                need_config = 1'b0;
            end
            goal = frames_predicted + 1;
            if ($urandom_range(0, 5) == 0) begin
                feed_pixels($urandom_range(1, cur_w * cur_h));
                need_config = 1'b1;
            end else begin
                feed_pixels(cur_w * cur_h);
                drain_frame(goal);
            end
        end

        // ---- wrap up ----
        s_valid <= 1'b0;
        drain_wait = 0;
        while (medians_pending != 0 && drain_wait < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain_wait++;
        end
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Summary: %0d pixel beats, %0d flush beats, %0d register writes, %0d frames",
                 pixel_beats, flush_beats, reg_writes, frames_predicted);
        $display("Summary: %0d medians compared, %0d failures, %0d cycles",
                 medians_checked, fail_count, cycle_count);
        if (medians_pending != 0)
            $display("%0d predicted medians never came out", medians_pending);
        if (fail_count == 0 && medians_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
